// ----- rtl/core/json_token_scanner_assert.svh -----
// Assertion macros for the JSON token scanner.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef JSON_TOKEN_SCANNER_ASSERT_SVH
`define JSON_TOKEN_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define JTS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("json_token_scanner: assertion failed");
`define JTS_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("json_token_scanner: forbidden condition seen");
`else
`define JTS_ASSERT(name, prop)
`define JTS_NEVER(name, cond)
`endif

`endif

// ----- rtl/core/jts_pkg.sv -----
package jts_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  tok_kind;
    logic [31:0] token_start;
    logic [15:0] token_length;
    logic        has_escapes;
    logic [6:0]  nest_depth;
    logic [2:0]  status;
    logic        last_result;
  } out_item_t;

  // Token kinds
  localparam logic [3:0] KIND_BEGIN_OBJ = 4'd0;
  localparam logic [3:0] KIND_END_OBJ   = 4'd1;
  localparam logic [3:0] KIND_BEGIN_ARR = 4'd2;
  localparam logic [3:0] KIND_END_ARR   = 4'd3;
  localparam logic [3:0] KIND_NAME      = 4'd4;
  localparam logic [3:0] KIND_STRING    = 4'd5;
  localparam logic [3:0] KIND_NUMBER    = 4'd6;
  localparam logic [3:0] KIND_TRUE      = 4'd7;
  localparam logic [3:0] KIND_FALSE     = 4'd8;
  localparam logic [3:0] KIND_NULL      = 4'd9;

  // Status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_BAD_CHAR = 3'd1;
  localparam logic [2:0] STAT_BAD_END  = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW = 3'd3;
  localparam logic [2:0] STAT_DONE     = 3'd4;

  localparam int RESULTS_MAX = 3;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // Literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_num_delim(input logic [7:0] c);
    return c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK || is_ws(c);
  endfunction

  function automatic logic is_simple_esc(input logic [7:0] c);
    return c == CH_BSLASH || c == CH_QUOTE || c == 8'h2F || c == 8'h62 ||
           c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74;
  endfunction

  // Expected byte of a literal at a given position
  function automatic logic [7:0] lit_byte(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (sel)
      LIT_TRUE: begin
        unique case (idx)
          3'd0:    b = 8'h74;
          3'd1:    b = 8'h72;
          3'd2:    b = 8'h75;
          default: b = 8'h65;
        endcase
      end
      LIT_FALSE: begin
        unique case (idx)
          3'd0:    b = 8'h66;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h6C;
          3'd3:    b = 8'h73;
          default: b = 8'h65;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    b = 8'h6E;
          3'd1:    b = 8'h75;
          default: b = 8'h6C;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic out_item_t mk_result(input logic [3:0] kind, input logic [31:0] start,
                                          input logic [15:0] len, input logic esc,
                                          input logic [6:0] dep, input logic [2:0] stat);
    out_item_t r;
    r.tok_kind     = kind;
    r.token_start  = start;
    r.token_length = len;
    r.has_escapes  = esc;
    r.nest_depth   = dep;
    r.status       = stat;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/core/jts_scan.sv -----
module jts_scan import jts_pkg::*; #(
  parameter int MAX_NEST_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            acc,
  input  in_item_t        item,
  input  logic [6:0]      depth_limit,
  output out_item_t       res [RESULTS_MAX],
  output logic [1:0]      res_n
);

  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam int CW = (DW > 7) ? DW : 7;

  typedef enum logic [4:0] {
    S_FIRST, S_OBJ_OPEN, S_ARR_OPEN, S_VALUE, S_NAME_NEXT, S_AFTER,
    S_STR, S_STR_ESC, S_STR_HEX, S_NAME, S_NAME_ESC, S_NAME_HEX, S_COLON,
    S_NUM_MINUS, S_NUM_ZERO, S_NUM_INT, S_NUM_DOT, S_NUM_FRAC,
    S_NUM_EXP, S_NUM_EXPSIGN, S_NUM_EXPDIG,
    S_LIT_TRUE, S_LIT_FALSE, S_LIT_NULL
  } scan_t;

  scan_t                     st, st_next;
  logic [DW-1:0]             depth, depth_next;
  logic [MAX_NEST_DEPTH-1:0] stack, stack_next;
  logic [31:0]               offset, offset_next;
  logic [15:0]               run_len, run_len_next;
  logic [31:0]               run_start, run_start_next;
  logic [2:0]                hex_cnt, hex_cnt_next;
  logic                      esc, esc_next;
  logic                      cplx, cplx_next;
  logic                      err, err_next;

  logic [7:0]  c;
  logic        do_after, do_value, do_close, close_obj, num_ok;
  logic [2:0]  fail_stat;
  logic [1:0]  n;
  logic [1:0]  lit_sel;
  logic [15:0] lit_len;
  logic [3:0]  lit_kind;

  function automatic logic num_accepting(input scan_t s);
    return s == S_NUM_ZERO || s == S_NUM_INT || s == S_NUM_FRAC || s == S_NUM_EXPDIG;
  endfunction

  // Scan one byte: next state and up to three results
  always_comb begin
    st_next        = st;
    depth_next     = depth;
    stack_next     = stack;
    offset_next    = offset;
    run_len_next   = run_len;
    run_start_next = run_start;
    hex_cnt_next   = hex_cnt;
    esc_next       = esc;
    cplx_next      = cplx;
    err_next       = err;
    c              = item.data_byte;
    do_after       = 1'b0;
    do_value       = 1'b0;
    do_close       = 1'b0;
    close_obj      = 1'b0;
    fail_stat      = STAT_OK;
    num_ok         = 1'b0;
    n              = 2'd0;
    lit_sel        = LIT_TRUE;
    lit_len        = 16'd4;
    lit_kind       = KIND_TRUE;
    for (int i = 0; i < RESULTS_MAX; i++) res[i] = '0;

    if (acc && err) begin
      // Drop bytes until the payload ends, then clear everything
      if (item.last_byte) begin
        st_next        = S_FIRST;
        depth_next     = '0;
        stack_next     = '0;
        offset_next    = '0;
        run_len_next   = '0;
        run_start_next = '0;
        hex_cnt_next   = '0;
        esc_next       = 1'b0;
        cplx_next      = 1'b0;
        err_next       = 1'b0;
      end else begin
        offset_next = sat_inc32(offset);
      end
    end else if (acc) begin
      unique case (st)
        S_FIRST, S_VALUE: begin
          do_value = !is_ws(c);
        end
        S_OBJ_OPEN, S_NAME_NEXT: begin
          if (!is_ws(c)) begin
            if (c == CH_QUOTE) begin
              st_next        = S_NAME;
              run_start_next = sat_inc32(offset);
              run_len_next   = '0;
              esc_next       = 1'b0;
              hex_cnt_next   = '0;
            end else if (c == CH_RBRACE && st == S_OBJ_OPEN) begin
              do_close  = 1'b1;
              close_obj = 1'b1;
            end else begin
              fail_stat = STAT_BAD_CHAR;
            end
          end
        end
        S_ARR_OPEN: begin
          if (!is_ws(c)) begin
            if (c == CH_RBRACK) do_close = 1'b1;
            else do_value = 1'b1;
          end
        end
        S_AFTER: do_after = 1'b1;
        S_STR, S_NAME: begin
          if (c == CH_QUOTE) begin
            if (st == S_NAME) begin
              st_next = S_COLON;
            end else begin
              res[n] = mk_result(KIND_STRING, run_start, run_len, esc, 7'(depth), STAT_OK);
              n = n + 2'd1;
              st_next = S_AFTER;
            end
          end else if (c == CH_BSLASH) begin
            esc_next     = 1'b1;
            run_len_next = sat_inc16(run_len);
            st_next      = (st == S_NAME) ? S_NAME_ESC : S_STR_ESC;
          end else if (c < 8'h20) begin
            fail_stat = STAT_BAD_CHAR;
          end else begin
            run_len_next = sat_inc16(run_len);
          end
        end
        S_STR_ESC, S_NAME_ESC: begin
          if (c == 8'h75) begin
            run_len_next = sat_inc16(run_len);
            hex_cnt_next = '0;
            st_next      = (st == S_NAME_ESC) ? S_NAME_HEX : S_STR_HEX;
          end else if (is_simple_esc(c)) begin
            run_len_next = sat_inc16(run_len);
            st_next      = (st == S_NAME_ESC) ? S_NAME : S_STR;
          end else begin
            fail_stat = STAT_BAD_CHAR;
          end
        end
        S_STR_HEX, S_NAME_HEX: begin
          if (!is_hex(c)) begin
            fail_stat = STAT_BAD_CHAR;
          end else begin
            run_len_next = sat_inc16(run_len);
            if (hex_cnt >= 3'd3) begin
              hex_cnt_next = '0;
              st_next      = (st == S_NAME_HEX) ? S_NAME : S_STR;
            end else begin
              hex_cnt_next = hex_cnt + 3'd1;
            end
          end
        end
        S_COLON: begin
          if (!is_ws(c)) begin
            if (c == CH_COLON) begin
              res[n] = mk_result(KIND_NAME, run_start, run_len, esc, 7'(depth), STAT_OK);
              n = n + 2'd1;
              st_next = S_VALUE;
            end else begin
              fail_stat = STAT_BAD_CHAR;
            end
          end
        end
        S_LIT_TRUE, S_LIT_FALSE, S_LIT_NULL: begin
          if (st == S_LIT_FALSE) begin
            lit_sel  = LIT_FALSE;
            lit_len  = 16'd5;
            lit_kind = KIND_FALSE;
          end else if (st == S_LIT_NULL) begin
            lit_sel  = LIT_NULL;
            lit_kind = KIND_NULL;
          end
          if (run_len < lit_len && c == lit_byte(lit_sel, run_len[2:0])) begin
            run_len_next = run_len + 16'd1;
            if (run_len_next == lit_len) begin
              res[n] = mk_result(lit_kind, run_start, lit_len, 1'b0, 7'(depth), STAT_OK);
              n = n + 2'd1;
              st_next = S_AFTER;
            end
          end else begin
            fail_stat = STAT_BAD_CHAR;
          end
        end
        default: begin
          // Number grammar; a delimiter ends the number and is scanned again
          if (num_accepting(st) && is_num_delim(c)) begin
            res[n] = mk_result(KIND_NUMBER, run_start, run_len, 1'b0, 7'(depth), STAT_OK);
            n = n + 2'd1;
            st_next  = S_AFTER;
            do_after = 1'b1;
          end else begin
            if (st == S_NUM_MINUS && is_digit(c))
              st_next = (c == CH_ZERO) ? S_NUM_ZERO : S_NUM_INT;
            else if (st == S_NUM_INT && is_digit(c))
              st_next = S_NUM_INT;
            else if ((st == S_NUM_ZERO || st == S_NUM_INT) && c == CH_DOT)
              st_next = S_NUM_DOT;
            else if ((st == S_NUM_ZERO || st == S_NUM_INT || st == S_NUM_FRAC) &&
                     (c == 8'h65 || c == 8'h45))
              st_next = S_NUM_EXP;
            else if ((st == S_NUM_DOT || st == S_NUM_FRAC) && is_digit(c))
              st_next = S_NUM_FRAC;
            else if (st == S_NUM_EXP && (c == CH_PLUS || c == CH_MINUS))
              st_next = S_NUM_EXPSIGN;
            else if ((st == S_NUM_EXP || st == S_NUM_EXPSIGN || st == S_NUM_EXPDIG) &&
                     is_digit(c))
              st_next = S_NUM_EXPDIG;
            else
              fail_stat = STAT_BAD_CHAR;
            if (fail_stat == STAT_OK) run_len_next = sat_inc16(run_len);
          end
        end
      endcase

      // Separator or closer after a complete value
      if (do_after && !is_ws(c)) begin
        if (depth == '0) begin
          fail_stat = STAT_BAD_CHAR;
        end else if (c == CH_COMMA) begin
          st_next = stack[0] ? S_NAME_NEXT : S_VALUE;
        end else if (c == CH_RBRACE) begin
          do_close  = 1'b1;
          close_obj = 1'b1;
        end else if (c == CH_RBRACK) begin
          do_close = 1'b1;
        end else begin
          fail_stat = STAT_BAD_CHAR;
        end
      end

      // Start of a value
      if (do_value) begin
        if (c == CH_QUOTE || c == CH_MINUS || is_digit(c) ||
            c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
          run_start_next = (c == CH_QUOTE) ? sat_inc32(offset) : offset;
          run_len_next   = (c == CH_QUOTE) ? 16'd0 : 16'd1;
          esc_next       = 1'b0;
          hex_cnt_next   = '0;
          if (c == CH_QUOTE)       st_next = S_STR;
          else if (c == CH_MINUS)  st_next = S_NUM_MINUS;
          else if (c == CH_ZERO)   st_next = S_NUM_ZERO;
          else if (is_digit(c))    st_next = S_NUM_INT;
          else if (c == 8'h74)     st_next = S_LIT_TRUE;
          else if (c == 8'h66)     st_next = S_LIT_FALSE;
          else                     st_next = S_LIT_NULL;
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
          if (CW'(depth) >= CW'(depth_limit) || depth == DW'(MAX_NEST_DEPTH)) begin
            fail_stat = STAT_OVERFLOW;
          end else begin
            if (st == S_FIRST) cplx_next = 1'b1;
            stack_next = (stack << 1) | MAX_NEST_DEPTH'(c == CH_LBRACE);
            depth_next = depth + DW'(1);
            res[n] = mk_result((c == CH_LBRACE) ? KIND_BEGIN_OBJ : KIND_BEGIN_ARR, offset,
                               16'd1, 1'b0, 7'(depth_next), STAT_OK);
            n = n + 2'd1;
            st_next = (c == CH_LBRACE) ? S_OBJ_OPEN : S_ARR_OPEN;
          end
        end else begin
          fail_stat = STAT_BAD_CHAR;
        end
      end

      // Pop a container, checking its kind
      if (do_close) begin
        if (depth == '0 || stack[0] != close_obj) begin
          fail_stat = STAT_BAD_CHAR;
        end else begin
          depth_next = depth - DW'(1);
          stack_next = stack >> 1;
          res[n] = mk_result(close_obj ? KIND_END_OBJ : KIND_END_ARR, offset, 16'd1, 1'b0,
                             7'(depth_next), STAT_OK);
          n = n + 2'd1;
          st_next = S_AFTER;
        end
      end

      if (fail_stat != STAT_OK) begin
        res[n] = mk_result(KIND_BEGIN_OBJ, offset, 16'd0, 1'b0, 7'(depth_next), fail_stat);
        n = n + 2'd1;
        err_next = 1'b1;
      end

      // End of payload: report and clear
      if (item.last_byte) begin
        if (!err_next) begin
          num_ok = num_accepting(st_next);
          if (num_ok && depth_next == '0 && !cplx_next) begin
            res[n] = mk_result(KIND_NUMBER, run_start_next, run_len_next, 1'b0, 7'(depth_next),
                               STAT_OK);
            n = n + 2'd1;
            res[n] = mk_result(KIND_BEGIN_OBJ, offset, 16'd0, 1'b0, 7'(depth_next), STAT_DONE);
            n = n + 2'd1;
          end else if (st_next == S_AFTER && depth_next == '0) begin
            res[n] = mk_result(KIND_BEGIN_OBJ, offset, 16'd0, 1'b0, 7'(depth_next), STAT_DONE);
            n = n + 2'd1;
          end else begin
            res[n] = mk_result(KIND_BEGIN_OBJ, offset, 16'd0, 1'b0, 7'(depth_next),
                               STAT_BAD_END);
            n = n + 2'd1;
          end
        end
        st_next        = S_FIRST;
        depth_next     = '0;
        stack_next     = '0;
        offset_next    = '0;
        run_len_next   = '0;
        run_start_next = '0;
        hex_cnt_next   = '0;
        esc_next       = 1'b0;
        cplx_next      = 1'b0;
        err_next       = 1'b0;
      end else begin
        offset_next = sat_inc32(offset);
      end

      if (n != 2'd0) res[n - 2'd1].last_result = 1'b1;
    end
  end

  assign res_n = n;

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_FIRST;
      depth     <= '0;
      stack     <= '0;
      offset    <= '0;
      run_len   <= '0;
      run_start <= '0;
      hex_cnt   <= '0;
      esc       <= 1'b0;
      cplx      <= 1'b0;
      err       <= 1'b0;
    end else begin
      st        <= st_next;
      depth     <= depth_next;
      stack     <= stack_next;
      offset    <= offset_next;
      run_len   <= run_len_next;
      run_start <= run_start_next;
      hex_cnt   <= hex_cnt_next;
      esc       <= esc_next;
      cplx      <= cplx_next;
      err       <= err_next;
    end
  end

endmodule

// ----- rtl/core/json_token_scanner.sv -----
// Results of an accepted byte are written into the four-entry result queue in the
// cycle after; out_data shows the queue head. One byte is accepted per cycle while
// each byte yields at most one result and out_stall is low; input stalls while the
// queue, which drains one transaction per cycle unless out_stall, lacks room for three.
// Reset (rst, synchronous): empties the queue, returns the scanner to its start
// state with an empty nesting stack, and sets depth_limit to 64.
`include "json_token_scanner_assert.svh"

module json_token_scanner import jts_pkg::*; #(
  parameter int MAX_NEST_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0] depth_limit;
  out_item_t  queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       acc, pop;
  out_item_t  res [RESULTS_MAX];
  logic [1:0] res_n;

  // Accept a byte only while the queue has room for three results
  assign in_stall  = rst || (count > 3'd1);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  jts_scan #(
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .item        (in_data),
    .depth_limit (depth_limit),
    .res         (res),
    .res_n       (res_n)
  );

  // Hold the depth limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      depth_limit <= cfg_data;
    end
  end

  // Advance the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + res_n;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(res_n) - 3'(pop);
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    for (int i = 0; i < RESULTS_MAX; i++) begin
      if (2'(i) < res_n) queue[wr_ptr + 2'(i)] <= res[i];
    end
  end

  `JTS_ASSERT(a_queue_bound, count <= 3'd4)
  `JTS_ASSERT(a_status_is_last, out_valid && out_data.status != STAT_OK |-> out_data.last_result)
  `JTS_ASSERT(a_done_at_top, out_valid && out_data.status == STAT_DONE |-> out_data.nest_depth == 7'd0)

endmodule
